FILE: sv/mvt_pkg.sv
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants of the 4x4 matrix-vector transform.
// Holds the dimensions, the fixed-point format and the transaction payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package mvt_pkg;

  // Active matrix dimension (2 to 4) and number of fraction bits (8 to 24).
  localparam int unsigned DIM       = 4;
  localparam int unsigned FRAC_BITS = 16;

  // The store is always 4x4; elements beyond DIM are unused.
  localparam int unsigned STORE_N = 4;
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    op_e              op;
    logic [ROW_W-1:0] row_index;
    data_t            in_a;
    data_t            in_b;
    data_t            in_c;
    data_t            in_d;
  } in_item_t;

  typedef struct packed {
    data_t out_x;
    data_t out_y;
    data_t out_z;
    data_t out_w;
    logic  saturated;
  } out_item_t;

  // One in the fixed-point format, used for the identity matrix.
  localparam data_t FX_ONE = data_t'(64'd1 << FRAC_BITS);

  // Saturation bounds at the width of the full sum.
  localparam sum_t SAT_MAX = sum_t'(data_t'({1'b0, {(DATA_W-1){1'b1}}}));
  localparam sum_t SAT_MIN = sum_t'(data_t'({1'b1, {(DATA_W-1){1'b0}}}));

endpackage

`default_nettype wire

FILE: sv/mvt_if.sv
// ----------------------------------------------------------------------------
// mvt_if: valid/ready channels of the matrix-vector transform.
// One interface for the input transactions and one for the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mvt_in_if import mvt_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface mvt_out_if import mvt_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/mat4_vector_transform_core.sv
// Latency: a transform result passes through the product, pair-sum, dot-product and result registers before it shows.
// Throughput: one transaction per cycle, loads and transforms alike; the four
// pipeline stages advance together and hold only while the result register is full
// and not taken. A load takes effect for every transform accepted after it.
// Reset: asynchronous, active low; clears all valid bits and sets the identity matrix.
`default_nettype none

// ----------------------------------------------------------------------------
// mat4_vector_transform_core: 4x4 Q16.16 matrix times four-element vector.
// Row loads update a register matrix; transforms pass through a four-stage
// multiply, add, add and round-and-saturate pipeline.
// ----------------------------------------------------------------------------
module mat4_vector_transform_core import mvt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mvt_in_if.sink    in_i,
  mvt_out_if.source out_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;

  // The whole pipeline moves when the result register is empty or being taken.
  // Nothing can be lost on a stall because every stage freezes at once.
  logic advance;
  logic accept;
  logic load_en;

  assign advance  = !s4_valid_q || out_o.ready;
  assign accept   = in_i.valid && advance;
  assign load_en  = accept && (in_i.data.op == OP_LOAD);
  assign in_i.ready = advance;

  // The incoming vector (or row) as an array, element 0 first.
  data_t vec[STORE_N];

  assign vec[0] = in_i.data.in_a;
  assign vec[1] = in_i.data.in_b;
  assign vec[2] = in_i.data.in_c;
  assign vec[3] = in_i.data.in_d;

  // --------------------------------------------------------------------------
  // Matrix store. Each element is read at its own fixed multiplier, so it is
  // plain registers. Rows and columns beyond DIM are never written.
  // --------------------------------------------------------------------------
  data_t mat_q[STORE_N][STORE_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STORE_N; i++) begin
        for (int k = 0; k < STORE_N; k++) begin
          mat_q[i][k] <= (i == k) ? FX_ONE : '0;
        end
      end
    end else begin
      for (int i = 0; i < STORE_N; i++) begin
        for (int k = 0; k < STORE_N; k++) begin
          if (load_en && (in_i.data.row_index == ROW_W'(i)) && (i < DIM) && (k < DIM)) begin
            mat_q[i][k] <= vec[k];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits. Only transform transactions produce a result, so a load
  // enters the pipeline as a bubble.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= accept && (in_i.data.op == OP_XFORM);
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sixteen products, taken straight from the input so that each
  // transform sees the matrix as it stands at its own acceptance. Products
  // outside the active DIM x DIM block are forced to zero, which also makes
  // the unused result fields zero and never saturated.
  // --------------------------------------------------------------------------
  prod_t s1_prod_d[STORE_N][STORE_N];
  prod_t s1_prod_q[STORE_N][STORE_N];

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      for (int k = 0; k < STORE_N; k++) begin
        if ((i < DIM) && (k < DIM)) begin
          s1_prod_d[i][k] = prod_t'(mat_q[i][k]) * prod_t'(vec[k]);
        end else begin
          s1_prod_d[i][k] = '0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: pairwise sums of each row's products.
  // --------------------------------------------------------------------------
  pair_t s2_pair_d[STORE_N][2];
  pair_t s2_pair_q[STORE_N][2];

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      s2_pair_d[i][0] = pair_t'(s1_prod_q[i][0]) + pair_t'(s1_prod_q[i][1]);
      s2_pair_d[i][1] = pair_t'(s1_prod_q[i][2]) + pair_t'(s1_prod_q[i][3]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: the exact dot product of each row, 66 bits wide so that four
  // full-range products cannot overflow.
  // --------------------------------------------------------------------------
  sum_t s3_sum_d[STORE_N];
  sum_t s3_sum_q[STORE_N];

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      s3_sum_d[i] = sum_t'(s2_pair_q[i][0]) + sum_t'(s2_pair_q[i][1]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: the arithmetic shift drops the fraction bits with rounding
  // towards minus infinity, then each element is clipped to 32 bits. The
  // saturation flag is the OR of the four clip events.
  // --------------------------------------------------------------------------
  sum_t      shifted[STORE_N];
  data_t     res[STORE_N];
  logic      clip[STORE_N];
  out_item_t s4_item_d;
  out_item_t s4_item_q;

  always_comb begin
    for (int i = 0; i < STORE_N; i++) begin
      shifted[i] = s3_sum_q[i] >>> FRAC_BITS;
      if (shifted[i] > SAT_MAX) begin
        res[i]  = SAT_MAX[DATA_W-1:0];
        clip[i] = 1'b1;
      end else if (shifted[i] < SAT_MIN) begin
        res[i]  = SAT_MIN[DATA_W-1:0];
        clip[i] = 1'b1;
      end else begin
        res[i]  = shifted[i][DATA_W-1:0];
        clip[i] = 1'b0;
      end
    end
    s4_item_d.out_x     = res[0];
    s4_item_d.out_y     = res[1];
    s4_item_d.out_z     = res[2];
    s4_item_d.out_w     = res[3];
    s4_item_d.saturated = clip[0] | clip[1] | clip[2] | clip[3];
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_prod_q <= s1_prod_d;
      s2_pair_q <= s2_pair_d;
      s3_sum_q  <= s3_sum_d;
      s4_item_q <= s4_item_d;
    end
  end

  assign out_o.valid = s4_valid_q;
  assign out_o.data  = s4_item_q;

endmodule

`default_nettype wire

FILE: sv/mvt_checker.sv
// ----------------------------------------------------------------------------
// mvt_checker: port-level assertions for the matrix-vector transform.
// Attached to the top level by the bind statement at the end of this file.
// ----------------------------------------------------------------------------
`default_nettype none

module mvt_checker import mvt_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  // A result that is not taken stays in place, unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result transaction changed or vanished while stalled");

  // A result only disappears through a completed transaction.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result valid fell without a completed transaction");

  // An empty result register never holds back the input.
  a_in_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled although the result register is empty");

  // The input is only held back by a stalled result.
  a_in_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a stalled result");

  // Input valid is watched for completeness of the stall rule above.
  a_in_valid_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |-> out_valid_i)
    else $error("input transaction refused with no result pending");

endmodule

bind mat4_vector_transform_core mvt_checker u_mvt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
